>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions, clocked on clk and held off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bmft_pkg.sv
// ----------------------------------------------------------------------------
// bmft_pkg
// Types and codes shared by the controller and datapath of the block-mapped
// flash translation unit.
// ----------------------------------------------------------------------------
package bmft_pkg;

  localparam int LPN_W  = 5;
  localparam int DATA_W = 31;
  localparam int CNT_W  = 32;

  localparam logic [1:0] ADDR_CUR = 2'd0;
  localparam logic [1:0] ADDR_NEW = 2'd1;
  localparam logic [1:0] ADDR_OLD = 2'd2;
  localparam logic [1:0] ADDR_CLR = 2'd3;

  localparam logic [1:0] WD_ZERO = 2'd0;
  localparam logic [1:0] WD_NEW  = 2'd1;
  localparam logic [1:0] WD_COPY = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] addr_sel;
    logic [1:0] wd_sel;
    logic       pcnt_clr;
    logic       pcnt_inc;
    logic       clr_inc;
    logic       copy_inc;
    logic       map_upd;
    logic       respond;
    logic       rsp_hit;
  } bmft_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_write;
    logic in_range;
    logic written;
    logic merge_ok;
    logic pcnt_is_off;
    logic pcnt_last;
  } bmft_sts_t;

endpackage

>>> design/bmft_ctrl.sv
// ----------------------------------------------------------------------------
// bmft_ctrl
// Sequencer for the translation unit: memory clearing after reset, lookup,
// in-place program, block merge with page copy, and erase of the old block.
// ----------------------------------------------------------------------------
module bmft_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bmft_pkg::bmft_sts_t sts,
  output bmft_pkg::bmft_cmd_t cmd
);
  import bmft_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_MRD   = 3'd4;
  localparam logic [2:0] S_MWR   = 3'd5;
  localparam logic [2:0] S_ERASE = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = ADDR_CLR;
        cmd.wd_sel   = WD_ZERO;
        cmd.clr_inc  = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.mem_rd   = sts.in_range;
        cmd.addr_sel = ADDR_CUR;
        state_nxt    = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.in_range) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end else if (!sts.is_write) begin
          cmd.respond = 1'b1;
          cmd.rsp_hit = sts.written;
          state_nxt   = S_IDLE;
        end else if (!sts.written) begin
          cmd.mem_wr   = 1'b1;
          cmd.addr_sel = ADDR_CUR;
          cmd.wd_sel   = WD_NEW;
          cmd.respond  = 1'b1;
          state_nxt    = S_IDLE;
        end else if (!sts.merge_ok) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.pcnt_clr = 1'b1;
          state_nxt    = S_MRD;
        end
      end
      S_MRD: begin
        if (sts.pcnt_is_off) begin
          cmd.mem_wr   = 1'b1;
          cmd.addr_sel = ADDR_NEW;
          cmd.wd_sel   = WD_NEW;
          if (sts.pcnt_last) begin
            cmd.pcnt_clr = 1'b1;
            state_nxt    = S_ERASE;
          end else begin
            cmd.pcnt_inc = 1'b1;
          end
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = ADDR_OLD;
          state_nxt    = S_MWR;
        end
      end
      S_MWR: begin
        if (sts.written) begin
          cmd.mem_wr   = 1'b1;
          cmd.addr_sel = ADDR_NEW;
          cmd.wd_sel   = WD_COPY;
          cmd.copy_inc = 1'b1;
        end
        if (sts.pcnt_last) begin
          cmd.pcnt_clr = 1'b1;
          state_nxt    = S_ERASE;
        end else begin
          cmd.pcnt_inc = 1'b1;
          state_nxt    = S_MRD;
        end
      end
      S_ERASE: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = ADDR_OLD;
        cmd.wd_sel   = WD_ZERO;
        if (sts.pcnt_last) begin
          cmd.map_upd = 1'b1;
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.pcnt_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/bmft_dp.sv
// ----------------------------------------------------------------------------
// bmft_dp
// Datapath: page split tables, block map, spare pointer, page memory with
// written flag, page and clear counters, copy counter and result registers.
// ----------------------------------------------------------------------------
module bmft_dp #(
  parameter int PAGES_IN_BLOCK  = 4,
  parameter int LOGICAL_BLOCKS  = 8,
  parameter int PHYSICAL_BLOCKS = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_func,
  input  logic [bmft_pkg::LPN_W-1:0]   in_logical_page,
  input  logic [bmft_pkg::DATA_W-1:0]  in_write_data,
  input  bmft_pkg::bmft_cmd_t          cmd,
  output bmft_pkg::bmft_sts_t          sts,
  output logic                         out_strobe,
  output logic [bmft_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_read_valid,
  output logic [bmft_pkg::CNT_W-1:0]   out_copied_pages
);
  import bmft_pkg::*;

  localparam int LPN_N     = 1 << LPN_W;
  localparam int LPN_SPAN  = (LPN_N + PAGES_IN_BLOCK - 1) / PAGES_IN_BLOCK;
  localparam int MAP_DEPTH = (LOGICAL_BLOCKS < LPN_SPAN) ? LOGICAL_BLOCKS : LPN_SPAN;
  localparam int MAP_IW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int BLK_MAX   = (PHYSICAL_BLOCKS > MAP_DEPTH) ? PHYSICAL_BLOCKS : MAP_DEPTH;
  localparam int BLK_W     = $clog2(BLK_MAX);
  localparam int OFF_W     = $clog2(PAGES_IN_BLOCK);
  localparam int TOTAL     = PHYSICAL_BLOCKS * PAGES_IN_BLOCK;
  localparam int ADDR_W    = $clog2(TOTAL);
  localparam int WORD_W    = DATA_W + 1;

  logic [LPN_W-1:0] lblk_tab [LPN_N];
  logic [OFF_W-1:0] off_tab  [LPN_N];
  logic             ok_tab   [LPN_N];

  for (genvar g = 0; g < LPN_N; g++) begin : g_split
    assign lblk_tab[g] = LPN_W'(g / PAGES_IN_BLOCK);
    assign off_tab[g]  = OFF_W'(g % PAGES_IN_BLOCK);
    assign ok_tab[g]   = ((g / PAGES_IN_BLOCK) < LOGICAL_BLOCKS);
  end

  logic [BLK_W-1:0]  map_r [MAP_DEPTH];
  logic [BLK_W-1:0]  spare_r;
  logic              func_r;
  logic [MAP_IW-1:0] lidx_r;
  logic [OFF_W-1:0]  off_r;
  logic [DATA_W-1:0] data_r;
  logic [BLK_W-1:0]  oldb_r;
  logic              rng_r;
  logic [OFF_W-1:0]  pcnt_r;
  logic [ADDR_W-1:0] clr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] mem [TOTAL];
  logic [WORD_W-1:0] rdata_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_valid_r;

  logic [LPN_W-1:0]  lblk_c;
  logic [MAP_IW-1:0] lidx_c;
  logic              ok_c;
  logic [BLK_W-1:0]  pblk_c;
  logic              rng_c;
  logic [BLK_W-1:0]  blk_sel;
  logic [OFF_W-1:0]  page_sel;
  logic [ADDR_W-1:0] addr;
  logic [WORD_W-1:0] wdata;

  assign lblk_c = lblk_tab[in_logical_page];
  assign lidx_c = lblk_c[MAP_IW-1:0];
  assign ok_c   = ok_tab[in_logical_page];
  assign pblk_c = ok_c ? map_r[lidx_c] : '0;
  assign rng_c  = ok_c && ({1'b0, pblk_c} < (BLK_W + 1)'(PHYSICAL_BLOCKS));

  always_comb begin
    blk_sel  = oldb_r;
    page_sel = pcnt_r;
    case (cmd.addr_sel)
      ADDR_CUR: begin
        blk_sel  = oldb_r;
        page_sel = off_r;
      end
      ADDR_NEW: begin
        blk_sel  = spare_r;
        page_sel = pcnt_r;
      end
      ADDR_OLD: begin
        blk_sel  = oldb_r;
        page_sel = pcnt_r;
      end
      default: begin
        blk_sel  = oldb_r;
        page_sel = pcnt_r;
      end
    endcase
  end

  always_comb begin
    if (cmd.addr_sel == ADDR_CLR) begin
      addr = clr_r;
    end else begin
      addr = ADDR_W'(blk_sel) * ADDR_W'(PAGES_IN_BLOCK) + ADDR_W'(page_sel);
    end
  end

  always_comb begin
    case (cmd.wd_sel)
      WD_ZERO: wdata = '0;
      WD_NEW:  wdata = {1'b1, data_r};
      WD_COPY: wdata = rdata_r;
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      lidx_r <= lidx_c;
      off_r  <= off_tab[in_logical_page];
      data_r <= in_write_data;
      oldb_r <= pblk_c;
      rng_r  <= rng_c;
    end
    if (cmd.respond) begin
      rd_data_r  <= cmd.rsp_hit ? rdata_r[DATA_W-1:0] : '0;
      rd_valid_r <= cmd.rsp_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAP_DEPTH; i++) begin
        map_r[i] <= BLK_W'(i);
      end
      spare_r     <= BLK_W'(PHYSICAL_BLOCKS - 1);
      pcnt_r      <= '0;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
      if (cmd.map_upd) begin
        map_r[lidx_r] <= spare_r;
        spare_r       <= oldb_r;
      end
      if (cmd.pcnt_clr) begin
        pcnt_r <= '0;
      end else if (cmd.pcnt_inc) begin
        pcnt_r <= pcnt_r + 1'b1;
      end
      if (cmd.clr_inc) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.copy_inc && (cnt_r != '1)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign sts.clr_last    = (clr_r == ADDR_W'(TOTAL - 1));
  assign sts.is_write    = func_r;
  assign sts.in_range    = rng_r;
  assign sts.written     = rdata_r[WORD_W-1];
  assign sts.merge_ok    = ({1'b0, spare_r} < (BLK_W + 1)'(PHYSICAL_BLOCKS)) &&
                           (spare_r != oldb_r);
  assign sts.pcnt_is_off = (pcnt_r == off_r);
  assign sts.pcnt_last   = (pcnt_r == OFF_W'(PAGES_IN_BLOCK - 1));

  assign out_strobe       = out_valid_r;
  assign out_read_data    = rd_data_r;
  assign out_read_valid   = rd_valid_r;
  assign out_copied_pages = cnt_r;

endmodule

>>> design/block_mapped_flash_translation_unit.sv
// ----------------------------------------------------------------------------
// block_mapped_flash_translation_unit
// Block-mapped flash translation layer over a model flash array with one
// spare physical block.
//
// A command beat is taken when start is high and busy is low: in_func selects
// read (0) or write (1) of page in_logical_page; in_write_data is programmed
// on a write. Every command yields exactly one result beat, marked by
// out_strobe for one cycle: out_read_data and out_read_valid carry the page
// on a read of a programmed page and are zero otherwise, out_copied_pages the
// saturating count of pages copied by merges so far.
// A read, an out-of-range access, or a write to an erased page is answered
// from the evaluation state; the strobe follows in the next cycle, in which a
// new command may already be taken. A write to a programmed page merges the
// block through the single-port page memory: each other page is read from the
// old block and, if programmed, copied to the spare block; the target page is
// written there with the new data; the old block is then erased page by page.
// After reset, busy stays high while the page memory is swept to the erased
// state. The receiver cannot stall; each result is valid only in its strobe
// cycle.
// ----------------------------------------------------------------------------
module block_mapped_flash_translation_unit #(
  parameter int PAGES_IN_BLOCK  = 4,
  parameter int LOGICAL_BLOCKS  = 8,
  parameter int PHYSICAL_BLOCKS = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_func,
  input  logic [bmft_pkg::LPN_W-1:0]   in_logical_page,
  input  logic [bmft_pkg::DATA_W-1:0]  in_write_data,
  output logic                         out_strobe,
  output logic [bmft_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_read_valid,
  output logic [bmft_pkg::CNT_W-1:0]   out_copied_pages
);
  import bmft_pkg::*;

  bmft_cmd_t cmd;
  bmft_sts_t sts;

  bmft_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bmft_dp #(
    .PAGES_IN_BLOCK  (PAGES_IN_BLOCK),
    .LOGICAL_BLOCKS  (LOGICAL_BLOCKS),
    .PHYSICAL_BLOCKS (PHYSICAL_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_logical_page  (in_logical_page),
    .in_write_data    (in_write_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_strobe       (out_strobe),
    .out_read_data    (out_read_data),
    .out_read_valid   (out_read_valid),
    .out_copied_pages (out_copied_pages)
  );

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `ASSERT_SAME(a_result_after_work, out_strobe, $past(busy), "result beat without work")
  `ASSERT_NEXT(a_single_result, out_strobe, !out_strobe, "result beats back to back")
  `ASSERT_SAME(a_copy_in_merge, cmd.copy_inc, cmd.mem_wr && !cmd.respond,
               "page copy counted without a program")

endmodule
